[rtl/stpseq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpseq_pkg
// Shared types, constants and the coil table of the stepper move sequencer.
// ----------------------------------------------------------------------------
package stpseq_pkg;

    // Geometry of the motor and the position counter
    localparam int POSITION_COUNT = 4096;
    localparam int STEPS_PER_REV  = 64;
    localparam int POS_W          = 12;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int STEPS_W   = 16;
    localparam int RPM_W     = 16;
    localparam int DELAY_W   = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int COIL_W    = 4;

    // Step delay is (60000 / STEPS_PER_REV) / rpm; the dividend is folded at elaboration
    localparam int DIVIDEND = 60000 / STEPS_PER_REV;
    localparam int DIV_W    = $clog2(DIVIDEND + 1);
    localparam int CMP_W    = (DIV_W > DELAY_W) ? DIV_W : DELAY_W;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HOME = 2'd2;
    localparam logic [KIND_W-1:0] KIND_INIT = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOME_SPEED = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_DELAY_RST  = 10'd5;
    localparam logic [CFG_W-1:0] MAX_DELAY_RST  = 10'd500;
    localparam logic [CFG_W-1:0] HOME_SPEED_RST = 10'd30;

    localparam logic [COIL_W-1:0] COILS_OFF = 4'h0;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [STEPS_W-1:0] steps;
        logic [RPM_W-1:0]          move_rpm;
    } in_item_t;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pins;
        logic [POS_W-1:0]  position;
        logic              busy_res;
        logic              step_taken;
        logic              rejected;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] min_delay_ms;
        logic [CFG_W-1:0] max_delay_ms;
        logic [CFG_W-1:0] home_rpm;
    } cfg_t;

    // Classified command passed from the front to the back
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               backward;
        logic [STEPS_W-1:0] count;
        logic [DELAY_W-1:0] delay;
    } cmd_t;

    typedef struct packed {
        logic               busy;
        logic               homing;
        logic [DELAY_W-1:0] step_delay;
        logic [DELAY_W-1:0] delay_left;
    } back_status_t;

    // Active coils by phase index: A, A+B, B, B+C
    function automatic logic [COIL_W-1:0] coil_lookup(input logic [1:0] phase);
        logic [COIL_W-1:0] pattern;
        case (phase)
            2'd0:    pattern = 4'h1;
            2'd1:    pattern = 4'h3;
            2'd2:    pattern = 4'h2;
            default: pattern = 4'h6;
        endcase
        return pattern;
    endfunction

endpackage

[rtl/stpseq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpseq_front
// Accepts input words, classifies them and works out the step delay of a
// move or home with a serial restoring divider, then queues the command.
// ----------------------------------------------------------------------------
module stpseq_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  stpseq_pkg::in_item_t s_data,
    input  stpseq_pkg::cfg_t     cfg,
    output logic                 push,
    output stpseq_pkg::cmd_t     push_data,
    input  logic                 full
);

    localparam int CNT_W = $clog2(stpseq_pkg::DIV_W);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                        state_reg, state_next;
    logic [stpseq_pkg::KIND_W-1:0]     kind_reg;
    logic                              backward_reg;
    logic [stpseq_pkg::STEPS_W-1:0]    count_reg;
    logic [stpseq_pkg::RPM_W-1:0]      rpm_reg;
    logic [stpseq_pkg::RPM_W-1:0]      rem_reg, rem_next;
    logic [stpseq_pkg::DIV_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [stpseq_pkg::RPM_W:0]        trial;
    logic                              trial_ge;
    logic [stpseq_pkg::CMP_W-1:0]      quo_ext, min_ext, max_ext, lo_clamped, hi_clamped;
    logic [stpseq_pkg::DELAY_W-1:0]    delay;
    logic                              accept;

    assign s_ready = (state_reg == F_IDLE);
    assign accept  = s_valid && s_ready;

    // One quotient bit a cycle
    always_comb begin
        trial    = {rem_reg, quo_reg[stpseq_pkg::DIV_W-1]};
        trial_ge = (trial >= {1'b0, rpm_reg});
        rem_next = trial_ge ? stpseq_pkg::RPM_W'(trial - {1'b0, rpm_reg})
                            : trial[stpseq_pkg::RPM_W-1:0];
        quo_next = {quo_reg[stpseq_pkg::DIV_W-2:0], trial_ge};
    end

    // Clamp the quotient: min first, then max, zero rpm takes max, zero becomes one
    always_comb begin
        quo_ext    = stpseq_pkg::CMP_W'(quo_reg);
        min_ext    = stpseq_pkg::CMP_W'(cfg.min_delay_ms);
        max_ext    = stpseq_pkg::CMP_W'(cfg.max_delay_ms);
        lo_clamped = (quo_ext < min_ext) ? min_ext : quo_ext;
        hi_clamped = (lo_clamped > max_ext) ? max_ext : lo_clamped;
        if (rpm_reg == '0) begin
            hi_clamped = max_ext;
        end
        delay = stpseq_pkg::DELAY_W'(hi_clamped);
        if (delay == '0) begin
            delay = stpseq_pkg::DELAY_W'(1);
        end
    end

    assign push               = (state_reg == F_PUSH) && !full;
    assign push_data.kind     = kind_reg;
    assign push_data.backward = backward_reg;
    assign push_data.count    = count_reg;
    assign push_data.delay    = delay;

    // Sequence: take word, divide where needed, hand over
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    if (s_data.kind == stpseq_pkg::KIND_MOVE ||
                        s_data.kind == stpseq_pkg::KIND_HOME) begin
                        state_next = F_DIV;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Latch the word and run the divider
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg     <= s_data.kind;
            backward_reg <= s_data.steps[stpseq_pkg::STEPS_W-1];
            count_reg    <= s_data.steps[stpseq_pkg::STEPS_W-1]
                            ? stpseq_pkg::STEPS_W'(-s_data.steps)
                            : stpseq_pkg::STEPS_W'(s_data.steps);
            if (s_data.kind == stpseq_pkg::KIND_HOME) begin
                rpm_reg <= stpseq_pkg::RPM_W'(cfg.home_rpm);
            end else begin
                rpm_reg <= s_data.move_rpm;
            end
            rem_reg <= '0;
            quo_reg <= stpseq_pkg::DIV_W'(stpseq_pkg::DIVIDEND);
            cnt_reg <= CNT_W'(stpseq_pkg::DIV_W - 1);
        end else if (state_reg == F_DIV) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

endmodule

[rtl/stpseq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpseq_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module stpseq_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  stpseq_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output stpseq_pkg::cmd_t pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stpseq_pkg::cmd_t  entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              do_push, do_pop;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/stpseq_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpseq_back
// Carries out queued commands, one a cycle when the output is free or read:
// motion state, coil phase and position, and the registered result word.
// ----------------------------------------------------------------------------
module stpseq_back (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stpseq_pkg::cmd_t         cmd,
    input  logic                     cmd_valid,
    output logic                     cmd_pop,
    output logic                     m_valid,
    input  logic                     m_ready,
    output stpseq_pkg::out_item_t    m_data,
    output stpseq_pkg::back_status_t status
);

    logic [stpseq_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [stpseq_pkg::COIL_W-1:0]  coil_reg, coil_next;
    logic [stpseq_pkg::STEPS_W-1:0] steps_left_reg, steps_left_next;
    logic                           backward_reg, backward_next;
    logic [stpseq_pkg::DELAY_W-1:0] step_delay_reg, step_delay_next;
    logic [stpseq_pkg::DELAY_W-1:0] delay_left_reg, delay_left_next;
    logic                           busy_reg, busy_next;
    logic                           homing_reg, homing_next;
    logic                           m_valid_reg;
    stpseq_pkg::out_item_t          m_data_reg, m_data_next;

    logic                           do_step, step_back, do_clear, stepped, rej;
    logic [stpseq_pkg::DELAY_W-1:0] dl_dec;

    assign cmd_pop = cmd_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.busy       = busy_reg;
    assign status.homing     = homing_reg;
    assign status.step_delay = step_delay_reg;
    assign status.delay_left = delay_left_reg;

    // Apply one command to the motion state
    always_comb begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        coil_next       = coil_reg;
        steps_left_next = steps_left_reg;
        backward_next   = backward_reg;
        step_delay_next = step_delay_reg;
        delay_left_next = delay_left_reg;
        busy_next       = busy_reg;
        homing_next     = homing_reg;
        do_step         = 1'b0;
        step_back       = backward_reg;
        do_clear        = 1'b0;
        stepped         = 1'b0;
        rej             = 1'b0;
        dl_dec          = (delay_left_reg != '0) ? delay_left_reg - stpseq_pkg::DELAY_W'(1)
                                                 : delay_left_reg;

        case (cmd.kind)
            stpseq_pkg::KIND_TICK: begin
                if (busy_reg) begin
                    delay_left_next = dl_dec;
                    if (dl_dec == '0) begin
                        if (steps_left_reg != '0) begin
                            do_step         = 1'b1;
                            steps_left_next = steps_left_reg - stpseq_pkg::STEPS_W'(1);
                            delay_left_next = step_delay_reg;
                            stepped         = 1'b1;
                        end else begin
                            busy_next = 1'b0;
                            if (homing_reg) begin
                                homing_next = 1'b0;
                                do_clear    = 1'b1;
                            end
                        end
                    end
                end
            end
            stpseq_pkg::KIND_MOVE: begin
                if (busy_reg) begin
                    rej = 1'b1;
                end else if (cmd.count != '0) begin
                    backward_next   = cmd.backward;
                    step_back       = cmd.backward;
                    step_delay_next = cmd.delay;
                    delay_left_next = cmd.delay;
                    steps_left_next = cmd.count - stpseq_pkg::STEPS_W'(1);
                    busy_next       = 1'b1;
                    do_step         = 1'b1;
                    stepped         = 1'b1;
                end
            end
            stpseq_pkg::KIND_HOME: begin
                if (busy_reg) begin
                    rej = 1'b1;
                end else if (pos_reg != '0) begin
                    homing_next     = 1'b1;
                    backward_next   = 1'b1;
                    step_back       = 1'b1;
                    step_delay_next = cmd.delay;
                    delay_left_next = cmd.delay;
                    steps_left_next = stpseq_pkg::STEPS_W'(pos_reg)
                                      - stpseq_pkg::STEPS_W'(1);
                    busy_next       = 1'b1;
                    do_step         = 1'b1;
                    stepped         = 1'b1;
                end else begin
                    do_clear = 1'b1;
                end
            end
            default: begin
                if (busy_reg) begin
                    rej = 1'b1;
                end else begin
                    do_clear = 1'b1;
                end
            end
        endcase

        // Move phase and position by one step
        if (do_step) begin
            if (step_back) begin
                phase_next = phase_reg - 2'd1;
                pos_next   = (pos_reg == '0) ? stpseq_pkg::POS_W'(stpseq_pkg::POSITION_COUNT - 1)
                                             : pos_reg - stpseq_pkg::POS_W'(1);
            end else begin
                phase_next = phase_reg + 2'd1;
                pos_next   = (pos_reg == stpseq_pkg::POS_W'(stpseq_pkg::POSITION_COUNT - 1))
                             ? '0 : pos_reg + stpseq_pkg::POS_W'(1);
            end
            coil_next = stpseq_pkg::coil_lookup(phase_next);
        end

        if (do_clear) begin
            pos_next   = '0;
            phase_next = 2'd0;
            coil_next  = stpseq_pkg::COILS_OFF;
        end

        m_data_next.coil_pins  = ~coil_next;
        m_data_next.position   = pos_next;
        m_data_next.busy_res   = busy_next;
        m_data_next.step_taken = stepped;
        m_data_next.rejected   = rej;
    end

    // Commit state and load the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            phase_reg      <= 2'd0;
            coil_reg       <= stpseq_pkg::COILS_OFF;
            steps_left_reg <= '0;
            backward_reg   <= 1'b0;
            step_delay_reg <= '0;
            delay_left_reg <= '0;
            busy_reg       <= 1'b0;
            homing_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd_pop) begin
                pos_reg        <= pos_next;
                phase_reg      <= phase_next;
                coil_reg       <= coil_next;
                steps_left_reg <= steps_left_next;
                backward_reg   <= backward_next;
                step_delay_reg <= step_delay_next;
                delay_left_reg <= delay_left_next;
                busy_reg       <= busy_next;
                homing_reg     <= homing_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

[rtl/stepper_move_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_move_sequencer_unit
// Unipolar stepper step sequencer: move, home, init and millisecond ticks.
// ----------------------------------------------------------------------------
// Every input word gives exactly one result word, in order. A move or home
// word is latched, put through the 10-bit restoring divide of 937 by the
// rpm at one quotient bit a cycle and queued; tick and init words skip the
// divide. The front takes no new word until the last is queued; the back
// retires one queued command a cycle into its output register when it is
// free or read. The user must write cfg_wr_en, cfg_index and cfg_wdata
// only while the block is idle; the block does not enforce it. No read-back.
// ----------------------------------------------------------------------------
module stepper_move_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  stpseq_pkg::in_item_t                s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output stpseq_pkg::out_item_t               m_data,
    input  logic                                cfg_wr_en,
    input  logic [stpseq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stpseq_pkg::CFG_W-1:0]        cfg_wdata
);

    stpseq_pkg::cfg_t         cfg_reg;
    stpseq_pkg::cmd_t         push_data, pop_data;
    stpseq_pkg::back_status_t status;
    logic                     push, full, pop, empty;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_delay_ms <= stpseq_pkg::MIN_DELAY_RST;
            cfg_reg.max_delay_ms <= stpseq_pkg::MAX_DELAY_RST;
            cfg_reg.home_rpm     <= stpseq_pkg::HOME_SPEED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                stpseq_pkg::REG_MIN_DELAY:  cfg_reg.min_delay_ms <= cfg_wdata;
                stpseq_pkg::REG_MAX_DELAY:  cfg_reg.max_delay_ms <= cfg_wdata;
                stpseq_pkg::REG_HOME_SPEED: cfg_reg.home_rpm     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    stpseq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    stpseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    stpseq_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (pop_data),
        .cmd_valid (!empty),
        .cmd_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .status    (status)
    );

    // Homing only ever runs as part of a motion
    a_homing_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        status.homing |-> status.busy)
        else $error("homing set while not busy");

    // A running motion never counts past its step delay, and the delay is never zero
    a_delay_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy |-> (status.delay_left <= status.step_delay && status.step_delay != '0))
        else $error("delay counter out of range");

    // A step always leaves the block busy
    a_step_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.step_taken) |-> m_data.busy_res)
        else $error("step reported while idle");

    // A rejected command never moves the motor
    a_reject_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.rejected) |-> (!m_data.step_taken && m_data.busy_res))
        else $error("rejected command stepped");

endmodule

[dv/stepper_move_sequencer_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_move_sequencer_unit_tb
// Self-checking bench for the stepper move sequencer. Command and tick words
// are driven through the input channel with random gaps. A cycle-free model
// of the motion state predicts one result word per input word. Results are
// taken with a randomly stalling ready and compared field by field, in order.
// A directed opening covers the clamps, wrap-around, homing and rejection.
// Random phases under several register settings follow.
// ----------------------------------------------------------------------------
module stepper_move_sequencer_unit_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MS_PER_MINUTE  = 60000;
    // Active coils by phase index, one nibble per phase: A, A+B, B, B+C
    localparam logic [15:0] PHASE_COILS = 16'h6231;

    // ------------------------------------------------------------------------
    // Motion model and store of expected result words
    // ------------------------------------------------------------------------
    class motion_scoreboard;
        logic [stpseq_pkg::CFG_W-1:0]   min_delay;
        logic [stpseq_pkg::CFG_W-1:0]   max_delay;
        logic [stpseq_pkg::CFG_W-1:0]   home_rpm;
        logic [stpseq_pkg::POS_W-1:0]   pos;
        logic [1:0]                     phase;
        logic [stpseq_pkg::COIL_W-1:0]  coils;
        logic [stpseq_pkg::STEPS_W-1:0] steps_left;
        logic                           backward;
        logic [stpseq_pkg::DELAY_W-1:0] step_delay;
        logic [stpseq_pkg::DELAY_W-1:0] delay_left;
        logic                           busy;
        logic                           homing;
        stpseq_pkg::out_item_t          expected_q[$];
        int                             errors;

        function new();
            min_delay  = stpseq_pkg::MIN_DELAY_RST;
            max_delay  = stpseq_pkg::MAX_DELAY_RST;
            home_rpm   = stpseq_pkg::HOME_SPEED_RST;
            clear_motor();
            steps_left = '0;
            backward   = 1'b0;
            step_delay = '0;
            delay_left = '0;
            busy       = 1'b0;
            homing     = 1'b0;
            errors     = 0;
        endfunction

        function void clear_motor();
            pos   = '0;
            phase = '0;
            coils = stpseq_pkg::COILS_OFF;
        endfunction

        // Milliseconds between steps: clamp to min first, then max
        function logic [stpseq_pkg::DELAY_W-1:0] delay_for(int unsigned rpm);
            int unsigned d;
            if (rpm == 0) begin
                d = 32'(max_delay);
            end else begin
                d = MS_PER_MINUTE / (rpm * stpseq_pkg::STEPS_PER_REV);
                if (d < 32'(min_delay)) d = 32'(min_delay);
                if (d > 32'(max_delay)) d = 32'(max_delay);
            end
            if (d == 0) d = 1;
            return d[stpseq_pkg::DELAY_W-1:0];
        endfunction

        // Advance one step in the current direction
        function void advance_one();
            if (backward) begin
                phase = phase - 2'd1;
                pos   = (pos == '0) ? stpseq_pkg::POS_W'(stpseq_pkg::POSITION_COUNT - 1)
                                    : pos - stpseq_pkg::POS_W'(1);
            end else begin
                phase = phase + 2'd1;
                pos   = (pos == stpseq_pkg::POS_W'(stpseq_pkg::POSITION_COUNT - 1))
                        ? '0 : pos + stpseq_pkg::POS_W'(1);
            end
            coils = PHASE_COILS[phase*4 +: 4];
        endfunction

        // Take the first step at once and arm the delay
        function void launch(int unsigned count, logic back, int unsigned rpm);
            backward   = back;
            step_delay = delay_for(rpm);
            advance_one();
            steps_left = stpseq_pkg::STEPS_W'(count - 1);
            delay_left = step_delay;
            busy       = 1'b1;
        endfunction

        // Apply an accepted input word and queue the result it causes
        function void note(stpseq_pkg::in_item_t w);
            stpseq_pkg::out_item_t e;
            logic                  stepped;
            logic                  rej;
            int                    s;
            stepped = 1'b0;
            rej     = 1'b0;
            s       = int'(w.steps);
            if (w.kind == stpseq_pkg::KIND_TICK) begin
                if (busy) begin
                    if (delay_left > 0) delay_left = delay_left - stpseq_pkg::DELAY_W'(1);
                    if (delay_left == 0) begin
                        if (steps_left > 0) begin
                            advance_one();
                            steps_left = steps_left - stpseq_pkg::STEPS_W'(1);
                            delay_left = step_delay;
                            stepped    = 1'b1;
                        end else begin
                            busy = 1'b0;
                            if (homing) begin
                                homing = 1'b0;
                                clear_motor();
                            end
                        end
                    end
                end
            end else if (busy) begin
                rej = 1'b1;
            end else begin
                case (w.kind)
                    stpseq_pkg::KIND_MOVE: begin
                        if (s != 0) begin
                            launch((s < 0) ? -s : s, s < 0, 32'(w.move_rpm));
                            stepped = 1'b1;
                        end
                    end
                    stpseq_pkg::KIND_HOME: begin
                        if (pos > 0) begin
                            homing = 1'b1;
                            launch(32'(pos), 1'b1, 32'(home_rpm));
                            stepped = 1'b1;
                        end else begin
                            clear_motor();
                        end
                    end
                    default: clear_motor();
                endcase
            end
            e.coil_pins  = ~coils;
            e.position   = pos;
            e.busy_res   = busy;
            e.step_taken = stepped;
            e.rejected   = rej;
            expected_q.push_back(e);
        endfunction

        // Compare a result word with the oldest expectation
        function void check(stpseq_pkg::out_item_t got);
            stpseq_pkg::out_item_t e;
            if (expected_q.size() == 0) begin
                $error("result word %h arrived with nothing expected", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.coil_pins !== e.coil_pins) begin
                $error("coil_pins: expected %0h, got %0h", e.coil_pins, got.coil_pins);
                errors++;
            end
            if (got.position !== e.position) begin
                $error("position: expected %0d, got %0d", e.position, got.position);
                errors++;
            end
            if (got.busy_res !== e.busy_res) begin
                $error("busy_res: expected %0b, got %0b", e.busy_res, got.busy_res);
                errors++;
            end
            if (got.step_taken !== e.step_taken) begin
                $error("step_taken: expected %0b, got %0b", e.step_taken, got.step_taken);
                errors++;
            end
            if (got.rejected !== e.rejected) begin
                $error("rejected: expected %0b, got %0b", e.rejected, got.rejected);
                errors++;
            end
        endfunction
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    stpseq_pkg::in_item_t             s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    stpseq_pkg::out_item_t            m_data;
    logic                             cfg_wr_en = 1'b0;
    logic [stpseq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [stpseq_pkg::CFG_W-1:0]     cfg_wdata = '0;

    motion_scoreboard sb = new();
    bit               quiet = 1'b0;
    int               ready_hold = 0;
    int               stuck_cycles = 0;

    stepper_move_sequencer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Stall the result channel at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
            m_ready    <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            ready_hold <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check(m_data);
    end

    // End the run when neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // Offer one word, hold it until accepted, then pass it to the model
    task automatic send_word(input logic [stpseq_pkg::KIND_W-1:0] kind, input int steps,
                             input int rpm);
        stpseq_pkg::in_item_t w;
        int                   gap;
        w.kind     = kind;
        w.steps    = steps[stpseq_pkg::STEPS_W-1:0];
        w.move_rpm = rpm[stpseq_pkg::RPM_W-1:0];
        gap = pick_gap();
        if ($urandom_range(0, 63) == 0) quiet = !quiet;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note(w);
    endtask

    task automatic send_tick();
        send_word(stpseq_pkg::KIND_TICK, $urandom, $urandom);
    endtask

    // Tick out any motion, drop valid, wait for every result and the pipeline
    task automatic settle();
        while (sb.busy) send_tick();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_config(input logic [stpseq_pkg::CFG_W-1:0] min_v,
                                input logic [stpseq_pkg::CFG_W-1:0] max_v,
                                input logic [stpseq_pkg::CFG_W-1:0] home_v);
        cfg_wr_en <= 1'b1;
        cfg_index <= stpseq_pkg::REG_MIN_DELAY;
        cfg_wdata <= min_v;
        @(posedge aclk);
        cfg_index <= stpseq_pkg::REG_MAX_DELAY;
        cfg_wdata <= max_v;
        @(posedge aclk);
        cfg_index <= stpseq_pkg::REG_HOME_SPEED;
        cfg_wdata <= home_v;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        sb.min_delay = min_v;
        sb.max_delay = max_v;
        sb.home_rpm  = home_v;
    endtask

    initial begin
        int ph;
        int lo;
        int hi;
        int done;
        int pick;
        int mag;
        int rpm;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle tick, home at zero, init, zero-step move
        send_tick();
        send_word(stpseq_pkg::KIND_HOME, 0, 0);
        send_word(stpseq_pkg::KIND_INIT, -1, 65535);
        send_word(stpseq_pkg::KIND_MOVE, 0, 123);
        // Fast move clamps to the min delay; every command is refused meanwhile
        send_word(stpseq_pkg::KIND_MOVE, 1, 65535);
        send_word(stpseq_pkg::KIND_MOVE, 32767, 65535);
        send_word(stpseq_pkg::KIND_HOME, -32768, 0);
        send_word(stpseq_pkg::KIND_INIT, 0, 0);
        while (sb.busy) send_tick();
        // Home at the home speed, refusing a move on the way
        send_word(stpseq_pkg::KIND_HOME, 0, 0);
        send_word(stpseq_pkg::KIND_MOVE, -32768, 1);
        while (sb.busy) send_tick();
        // Wrap below zero and back up through it
        send_word(stpseq_pkg::KIND_MOVE, -1, 100);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_MOVE, 1, 65535);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_MOVE, -3, 200);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_INIT, 0, 0);
        settle();

        // Widest clamps: one tick a step out and back home
        write_config(10'd1, 10'd1000, 10'd1000);
        send_word(stpseq_pkg::KIND_MOVE, 3, 65535);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_HOME, 0, 0);
        settle();

        // Crossed clamps: max wins for moves, zero rpm and homing alike
        write_config(10'd1000, 10'd1, 10'd1);
        send_word(stpseq_pkg::KIND_MOVE, 3, 7);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_MOVE, -2, 0);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_HOME, 0, 0);
        settle();

        // Equal clamps, with zero rpm taking the max
        write_config(10'd3, 10'd3, 10'd500);
        send_word(stpseq_pkg::KIND_MOVE, 1, 500);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_MOVE, 2, 0);
        while (sb.busy) send_tick();
        send_word(stpseq_pkg::KIND_INIT, 0, 0);
        settle();

        // Random phases; the third one crosses the clamps
        for (ph = 0; ph < 4; ph++) begin
            lo = (ph == 2) ? $urandom_range(6, 12) : $urandom_range(1, 4);
            hi = (ph == 2) ? $urandom_range(1, 5) : $urandom_range(lo, 12);
            write_config(stpseq_pkg::CFG_W'(lo), stpseq_pkg::CFG_W'(hi),
                         stpseq_pkg::CFG_W'($urandom_range(1, 1000)));
            done = 0;
            while (done < 55) begin
                pick = $urandom_range(0, 99);
                if (sb.busy) begin
                    if (pick < 88) begin
                        send_tick();
                        done++;
                    end else begin
                        send_word(stpseq_pkg::KIND_W'($urandom_range(1, 3)), $urandom, $urandom);
                    end
                end else if (pick < 65) begin
                    mag = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
                    case ($urandom_range(0, 9))
                        0:       rpm = 0;
                        1, 2, 3: rpm = $urandom_range(1, 200);
                        default: rpm = $urandom_range(0, 65535);
                    endcase
                    send_word(stpseq_pkg::KIND_MOVE, $urandom_range(0, 1) ? -mag : mag, rpm);
                    done++;
                end else if (pick < 85) begin
                    // Home only from near zero to keep the return short
                    if (pick < 77 && sb.pos <= 16) begin
                        send_word(stpseq_pkg::KIND_HOME, $urandom, $urandom);
                    end else begin
                        send_word(stpseq_pkg::KIND_INIT, $urandom, $urandom);
                    end
                    done++;
                end else begin
                    send_tick();
                end
            end
            settle();
        end

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
